[sv/ebl_pkg.sv]
// ----------------------------------------------------------------------------
// ebl_pkg - shared types and codes of the expression byte lexer
// Token kinds, byte classes and the classified item that goes from the
// front part to the back part.
// ----------------------------------------------------------------------------
package ebl_pkg;

    // token kinds on the result channel
    localparam logic [3:0] K_NUM  = 4'd0;
    localparam logic [3:0] K_EOF  = 4'd1;
    localparam logic [3:0] K_AND  = 4'd2;
    localparam logic [3:0] K_OR   = 4'd3;
    localparam logic [3:0] K_EQ   = 4'd4;
    localparam logic [3:0] K_NEQ  = 4'd5;
    localparam logic [3:0] K_ADD  = 4'd6;
    localparam logic [3:0] K_SUB  = 4'd7;
    localparam logic [3:0] K_MUL  = 4'd8;
    localparam logic [3:0] K_DIV  = 4'd9;
    localparam logic [3:0] K_MOD  = 4'd10;
    localparam logic [3:0] K_SEMI = 4'd11;
    localparam logic [3:0] K_ERR  = 4'd12;

    // byte classes found by the front part
    localparam logic [2:0] CLS_TERM   = 3'd0;
    localparam logic [2:0] CLS_SPACE  = 3'd1;
    localparam logic [2:0] CLS_DIGIT  = 3'd2;
    localparam logic [2:0] CLS_PEND   = 3'd3;
    localparam logic [2:0] CLS_SINGLE = 3'd4;
    localparam logic [2:0] CLS_OTHER  = 3'd5;

    // first byte codes of the two-byte operators
    localparam logic [1:0] PF_AMP  = 2'd0;
    localparam logic [1:0] PF_BAR  = 2'd1;
    localparam logic [1:0] PF_EQ   = 2'd2;
    localparam logic [1:0] PF_BANG = 2'd3;

    // classified item: aux is digit value, first byte code or token kind
    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] aux;
    } t_class_item;

    // head of the queue between front and back
    typedef struct packed {
        logic        valid;
        t_class_item item;
    } t_queue_head;

endpackage

[sv/expression_byte_lexer_unit.sv]
// ----------------------------------------------------------------------------
// expression_byte_lexer_unit - byte stream lexer for integer expressions
// The first token of a byte passes the input queue, then the output queue.
// Throughput: one byte per cycle while neither queue is full, set by the
// single-step lexer state update; a byte that closes a number and makes a
// second token puts both tokens in the output queue. Reset is synchronous
// and empties both queues and the lexer state.
// ----------------------------------------------------------------------------
module expression_byte_lexer_unit #(
    parameter int NUMBER_BITS = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_in_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [3:0]             o_token_kind,
    output logic [NUMBER_BITS-1:0] o_number_value,
    output logic                   o_number_saturated,
    output logic                   o_last_of_item
);
    import ebl_pkg::*;

    t_queue_head w_head;
    logic        w_pop;

    // intake and classification
    ebl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_byte  (i_in_byte),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    // lexer state and token output
    ebl_back #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (w_head),
        .o_pop              (w_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_token_kind       (o_token_kind),
        .o_number_value     (o_number_value),
        .o_number_saturated (o_number_saturated),
        .o_last_of_item     (o_last_of_item)
    );

endmodule

[sv/ebl_front.sv]
// ----------------------------------------------------------------------------
// ebl_front - byte intake and classification
// Accepts one byte per cycle while the queue is not full, sorts it into a class and places the result
// in a two-entry queue that the back part drains.
// ----------------------------------------------------------------------------
module ebl_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_in_byte,
    output ebl_pkg::t_queue_head o_head,
    input  logic                i_pop
);
    import ebl_pkg::*;

    t_class_item r_q [0:1];
    logic        r_wr, n_wr;
    logic        r_rd, n_rd;
    logic [1:0]  r_cnt, n_cnt;
    t_class_item w_cls;
    logic        w_push;
    logic        w_pop;

    // classify the incoming byte
    always_comb begin
        w_cls.cls = CLS_OTHER;
        w_cls.aux = 4'd0;
        if (i_in_byte == 8'd0 || i_in_byte == 8'd255) begin
            w_cls.cls = CLS_TERM;
        end else if (i_in_byte inside {8'd32, [8'd9:8'd13]}) begin
            w_cls.cls = CLS_SPACE;
        end else if (i_in_byte inside {[8'h30:8'h39]}) begin
            w_cls.cls = CLS_DIGIT;
            w_cls.aux = i_in_byte[3:0];
        end else begin
            case (i_in_byte)
                8'h26: begin w_cls.cls = CLS_PEND;   w_cls.aux = {2'b00, PF_AMP};  end
                8'h7c: begin w_cls.cls = CLS_PEND;   w_cls.aux = {2'b00, PF_BAR};  end
                8'h3d: begin w_cls.cls = CLS_PEND;   w_cls.aux = {2'b00, PF_EQ};   end
                8'h21: begin w_cls.cls = CLS_PEND;   w_cls.aux = {2'b00, PF_BANG}; end
                8'h2b: begin w_cls.cls = CLS_SINGLE; w_cls.aux = K_ADD;  end
                8'h2d: begin w_cls.cls = CLS_SINGLE; w_cls.aux = K_SUB;  end
                8'h2a: begin w_cls.cls = CLS_SINGLE; w_cls.aux = K_MUL;  end
                8'h2f: begin w_cls.cls = CLS_SINGLE; w_cls.aux = K_DIV;  end
                8'h25: begin w_cls.cls = CLS_SINGLE; w_cls.aux = K_MOD;  end
                8'h3b: begin w_cls.cls = CLS_SINGLE; w_cls.aux = K_SEMI; end
                default: begin
                    w_cls.cls = CLS_OTHER;
                    w_cls.aux = 4'd0;
                end
            endcase
        end
    end

    // queue control
    assign o_in_stall   = (r_cnt == 2'd2);
    assign w_push       = i_in_valid && !o_in_stall;
    assign w_pop        = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rd];

    always_comb begin
        n_wr  = w_push ? ~r_wr : r_wr;
        n_rd  = w_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cls;
        end
    end

endmodule

[sv/ebl_back.sv]
// ----------------------------------------------------------------------------
// ebl_back - lexer state and token output
// Takes classified items from the queue, runs the lexer state (number
// build, pending operator, error drop) and puts up to two tokens per item
// into a two-entry output queue.
// ----------------------------------------------------------------------------
module ebl_back #(
    parameter int NUMBER_BITS = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ebl_pkg::t_queue_head   i_head,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [3:0]             o_token_kind,
    output logic [NUMBER_BITS-1:0] o_number_value,
    output logic                   o_number_saturated,
    output logic                   o_last_of_item
);
    import ebl_pkg::*;

    localparam int NW = NUMBER_BITS;

    // lexer modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_NUM  = 2'd1;
    localparam logic [1:0] MODE_PEND = 2'd2;
    localparam logic [1:0] MODE_DROP = 2'd3;

    logic [1:0]    r_mode, n_mode;
    logic [1:0]    r_pf, n_pf;
    logic [NW-1:0] r_acc, n_acc;
    logic          r_asat, n_asat;

    // output queue
    logic [3:0]    r_kind [0:1];
    logic [NW-1:0] r_val  [0:1];
    logic          r_sat  [0:1];
    logic          r_last [0:1];
    logic          r_wr, r_rd;
    logic [1:0]    r_cnt;

    t_class_item   w_it;
    logic          w_term;
    logic          w_digit;
    logic          w_match;
    logic [3:0]    w_pair_kind;
    logic [NW-1:0] w_digit_ext;
    logic [NW+3:0] w_wide;
    logic [NW+3:0] w_max;

    // idle handling of the head item
    logic          id_tok;
    logic [3:0]    id_kind;
    logic [1:0]    id_mode;

    // tokens made by the head item
    logic [1:0]    w_n;
    logic [3:0]    w_kind0;
    logic [NW-1:0] w_val0;
    logic          w_sat0;
    logic [3:0]    w_kind1;

    logic          w_out_fire;
    logic [2:0]    w_cnt_after;

    assign w_it        = i_head.item;
    assign w_term      = (w_it.cls == CLS_TERM);
    assign w_digit     = (w_it.cls == CLS_DIGIT);
    assign w_digit_ext = {{(NW-4){1'b0}}, w_it.aux};

    // second byte check of a pending operator, '!' pairs with '='
    assign w_match = (w_it.cls == CLS_PEND) &&
                     (w_it.aux[1:0] == ((r_pf == PF_BANG) ? PF_EQ : r_pf));

    always_comb begin
        case (r_pf)
            PF_AMP:  w_pair_kind = K_AND;
            PF_BAR:  w_pair_kind = K_OR;
            PF_EQ:   w_pair_kind = K_EQ;
            default: w_pair_kind = K_NEQ;
        endcase
    end

    // times ten plus digit, checked against the maximum
    assign w_wide = ({4'b0000, r_acc} << 3) + ({4'b0000, r_acc} << 1)
                  + {4'b0000, w_digit_ext};
    assign w_max  = {4'b0000, {NW{1'b1}}};

    // what an idle lexer does with the head item
    always_comb begin
        id_tok  = 1'b0;
        id_kind = K_ERR;
        id_mode = MODE_IDLE;
        case (w_it.cls)
            CLS_TERM: begin
                id_tok  = 1'b1;
                id_kind = K_EOF;
            end
            CLS_SPACE: begin
                id_tok = 1'b0;
            end
            CLS_DIGIT: begin
                id_mode = MODE_NUM;
            end
            CLS_PEND: begin
                id_mode = MODE_PEND;
            end
            CLS_SINGLE: begin
                id_tok  = 1'b1;
                id_kind = w_it.aux;
            end
            default: begin
                id_tok  = 1'b1;
                id_kind = K_ERR;
                id_mode = MODE_DROP;
            end
        endcase
    end

    // lexer step
    always_comb begin
        n_mode  = r_mode;
        n_pf    = r_pf;
        n_acc   = r_acc;
        n_asat  = r_asat;
        w_n     = 2'd0;
        w_kind0 = K_NUM;
        w_val0  = '0;
        w_sat0  = 1'b0;
        w_kind1 = K_NUM;
        case (r_mode)
            MODE_DROP: begin
                if (w_term) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_PEND: begin
                w_n = 2'd1;
                if (w_match) begin
                    w_kind0 = w_pair_kind;
                    n_mode  = MODE_IDLE;
                end else begin
                    w_kind0 = K_ERR;
                    n_mode  = w_term ? MODE_IDLE : MODE_DROP;
                end
            end
            MODE_NUM: begin
                if (w_digit) begin
                    if (w_wide > w_max) begin
                        n_acc  = '1;
                        n_asat = 1'b1;
                    end else begin
                        n_acc = w_wide[NW-1:0];
                    end
                end else begin
                    w_n     = id_tok ? 2'd2 : 2'd1;
                    w_kind0 = K_NUM;
                    w_val0  = r_acc;
                    w_sat0  = r_asat;
                    w_kind1 = id_kind;
                    n_mode  = id_mode;
                    n_acc   = '0;
                    n_asat  = 1'b0;
                    if (w_it.cls == CLS_PEND) begin
                        n_pf = w_it.aux[1:0];
                    end
                end
            end
            default: begin
                w_n     = {1'b0, id_tok};
                w_kind0 = id_kind;
                n_mode  = id_mode;
                if (w_digit) begin
                    n_acc  = w_digit_ext;
                    n_asat = 1'b0;
                end
                if (w_it.cls == CLS_PEND) begin
                    n_pf = w_it.aux[1:0];
                end
            end
        endcase
    end

    // take the head item when its tokens fit in the output queue
    assign o_out_valid = (r_cnt != 2'd0);
    assign w_out_fire  = o_out_valid && !i_out_stall;
    assign w_cnt_after = {1'b0, r_cnt} - {2'b00, w_out_fire};
    assign o_pop       = i_head.valid && ((w_cnt_after + {1'b0, w_n}) <= 3'd2);

    assign o_token_kind       = r_kind[r_rd];
    assign o_number_value     = r_val[r_rd];
    assign o_number_saturated = r_sat[r_rd];
    assign o_last_of_item     = r_last[r_rd];

    // lexer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_pf   <= PF_AMP;
            r_acc  <= '0;
            r_asat <= 1'b0;
        end else if (o_pop) begin
            r_mode <= n_mode;
            r_pf   <= n_pf;
            r_acc  <= n_acc;
            r_asat <= n_asat;
        end
    end

    // output queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_out_fire) begin
                r_rd <= ~r_rd;
            end
            if (o_pop) begin
                r_wr  <= r_wr ^ w_n[0];
                r_cnt <= w_cnt_after[1:0] + w_n;
            end else begin
                r_cnt <= w_cnt_after[1:0];
            end
        end
    end

    // output queue storage
    always_ff @(posedge i_clk) begin
        if (o_pop && w_n != 2'd0) begin
            r_kind[r_wr] <= w_kind0;
            r_val[r_wr]  <= w_val0;
            r_sat[r_wr]  <= w_sat0;
            r_last[r_wr] <= (w_n == 2'd1);
        end
        if (o_pop && w_n == 2'd2) begin
            r_kind[~r_wr] <= w_kind1;
            r_val[~r_wr]  <= '0;
            r_sat[~r_wr]  <= 1'b0;
            r_last[~r_wr] <= 1'b1;
        end
    end

endmodule

[dv/tb_expression_byte_lexer_unit.sv]
// ----------------------------------------------------------------------------
// tb_expression_byte_lexer_unit - self-checking bench of the byte lexer
// Feeds source bytes through the valid/stall input port, predicts the token
// stream with a cycle-free model of the lexer state, and compares every token
// leaving the block field by field against the oldest predicted token.
// ----------------------------------------------------------------------------
module tb_expression_byte_lexer_unit;
    import ebl_pkg::*;

    localparam int NUM_W = 31;
    localparam longint unsigned NUM_MAX = (64'd1 << NUM_W) - 64'd1;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;

    // source characters the lexer gives meaning to
    localparam logic [7:0] CH_AMP   = "&";
    localparam logic [7:0] CH_BAR   = "|";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_PCT   = "%";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_AT    = "@";
    localparam logic [7:0] TERM_NUL = 8'h00;
    localparam logic [7:0] TERM_FF  = 8'hFF;

    typedef enum logic [1:0] {
        LX_IDLE    = 2'd0,
        LX_NUMBER  = 2'd1,
        LX_PENDING = 2'd2,
        LX_DROP    = 2'd3
    } t_lex_mode;

    typedef struct packed {
        logic [3:0]       kind;
        logic [NUM_W-1:0] value;
        logic             sat;
        logic             last;
    } t_token;

    // token predictor and store of tokens still to come out
    class t_token_scoreboard;
        t_lex_mode        mode;
        logic [1:0]       first;
        longint unsigned  accum;
        bit               accum_sat;
        t_token           expected_q[$];
        int               errors;
        int               useful;

        function new();
            mode      = LX_IDLE;
            first     = PF_AMP;
            accum     = 64'd0;
            accum_sat = 1'b0;
            errors    = 0;
            useful    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        static function bit is_term(logic [7:0] b);
            return b == TERM_NUL || b == TERM_FF;
        endfunction

        function void push_token(logic [3:0] kind, longint unsigned value, bit sat);
            t_token t;
            t.kind  = kind;
            t.value = value[NUM_W-1:0];
            t.sat   = sat;
            t.last  = 1'b0;
            expected_q.push_back(t);
        endfunction

        // byte seen with no number or operator under way
        function void idle_byte(logic [7:0] b);
            if (is_term(b)) begin
                push_token(K_EOF, 64'd0, 1'b0);
            end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
                // whitespace is skipped
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
                mode      = LX_NUMBER;
                accum     = 64'(b) - 64'(CH_ZERO);
                accum_sat = 1'b0;
            end else begin
                case (b)
                    CH_AMP: begin
                        mode  = LX_PENDING;
                        first = PF_AMP;
                    end
                    CH_BAR: begin
                        mode  = LX_PENDING;
                        first = PF_BAR;
                    end
                    CH_EQ: begin
                        mode  = LX_PENDING;
                        first = PF_EQ;
                    end
                    CH_BANG: begin
                        mode  = LX_PENDING;
                        first = PF_BANG;
                    end
                    CH_PLUS:  push_token(K_ADD, 64'd0, 1'b0);
                    CH_MINUS: push_token(K_SUB, 64'd0, 1'b0);
                    CH_STAR:  push_token(K_MUL, 64'd0, 1'b0);
                    CH_SLASH: push_token(K_DIV, 64'd0, 1'b0);
                    CH_PCT:   push_token(K_MOD, 64'd0, 1'b0);
                    CH_SEMI:  push_token(K_SEMI, 64'd0, 1'b0);
                    default: begin
                        mode = LX_DROP;
                        push_token(K_ERR, 64'd0, 1'b0);
                    end
                endcase
            end
        endfunction

        // predict the tokens of one accepted item
        function void note_byte(logic [7:0] b);
            int              before_n;
            logic [7:0]      partner;
            logic [3:0]      pair_kind;
            longint unsigned d;
            before_n = expected_q.size();
            useful++;
            case (mode)
                LX_DROP: begin
                    if (is_term(b)) mode = LX_IDLE;
                end
                LX_PENDING: begin
                    case (first)
                        PF_AMP: begin
                            partner   = CH_AMP;
                            pair_kind = K_AND;
                        end
                        PF_BAR: begin
                            partner   = CH_BAR;
                            pair_kind = K_OR;
                        end
                        PF_EQ: begin
                            partner   = CH_EQ;
                            pair_kind = K_EQ;
                        end
                        default: begin
                            partner   = CH_EQ;
                            pair_kind = K_NEQ;
                        end
                    endcase
                    if (b == partner) begin
                        push_token(pair_kind, 64'd0, 1'b0);
                        mode = LX_IDLE;
                    end else begin
                        push_token(K_ERR, 64'd0, 1'b0);
                        mode = is_term(b) ? LX_IDLE : LX_DROP;
                    end
                end
                LX_NUMBER: begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        // clamp at the top of the number range
                        d = 64'(b) - 64'(CH_ZERO);
                        if (accum > (NUM_MAX - d) / 64'd10) begin
                            accum     = NUM_MAX;
                            accum_sat = 1'b1;
                        end else begin
                            accum = accum * 64'd10 + d;
                        end
                    end else begin
                        push_token(K_NUM, accum, accum_sat);
                        mode      = LX_IDLE;
                        accum     = 64'd0;
                        accum_sat = 1'b0;
                        idle_byte(b);
                    end
                end
                default: idle_byte(b);
            endcase
            if (expected_q.size() > before_n) expected_q[expected_q.size()-1].last = 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // compare one token off the output port with the oldest prediction
        task check_token(t_token got);
            t_token want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("token kind %0d with none expected", got.kind));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.value !== want.value)
                report_mismatch($sformatf("value %0d, expected %0d", got.value, want.value));
            if (got.sat !== want.sat)
                report_mismatch($sformatf("saturated %0b, expected %0b", got.sat, want.sat));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [7:0]       i_in_byte;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [3:0]       o_token_kind;
    logic [NUM_W-1:0] o_number_value;
    logic             o_number_saturated;
    logic             o_last_of_item;

    bit                 idle_on = 1'b1;
    bit                 paused = 1'b0;
    int                 drain_cycles;
    t_token_scoreboard  sb = new();

    expression_byte_lexer_unit #(
        .NUMBER_BITS (NUM_W)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_in_byte          (i_in_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_token_kind       (o_token_kind),
        .o_number_value     (o_number_value),
        .o_number_saturated (o_number_saturated),
        .o_last_of_item     (o_last_of_item)
    );

    always #5 i_clk = ~i_clk;

    // random back-pressure on the token port
    always @(negedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < 37);
    end

    // token monitor
    always @(posedge i_clk) begin : token_monitor
        t_token got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind  = o_token_kind;
            got.value = o_number_value;
            got.sat   = o_number_saturated;
            got.last  = o_last_of_item;
            sb.check_token(got);
        end
    end

    // present one item, hold it until accepted, return at the next falling edge
    task automatic feed_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(b);
        @(negedge i_clk);
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++) feed_byte(8'(s.getc(i)));
    endtask

    // one random piece of source text, mostly well formed
    task automatic random_piece();
        int unsigned pick;
        int unsigned len;
        logic [7:0]  opener;
        logic [7:0]  partner;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (sb.mode == LX_DROP) begin
            if (pick < 40) feed_byte($urandom_range(1) ? TERM_NUL : TERM_FF);
            else feed_byte(8'($urandom_range(255)));
        end else if (pick < 30) begin
            // numbers, a few long enough to clamp
            if ($urandom_range(99) < 4) begin
                case ($urandom_range(2))
                    0: feed_text("2147483647");
                    1: feed_text("2147483648");
                    default: feed_text("0002147483646");
                endcase
            end else begin
                len = ($urandom_range(99) < 10) ? $urandom_range(14, 9) : $urandom_range(4, 1);
                repeat (len) feed_byte(CH_ZERO + 8'($urandom_range(9)));
            end
        end else if (pick < 55) begin
            case ($urandom_range(5))
                0: feed_byte(CH_PLUS);
                1: feed_byte(CH_MINUS);
                2: feed_byte(CH_STAR);
                3: feed_byte(CH_SLASH);
                4: feed_byte(CH_PCT);
                default: feed_byte(CH_SEMI);
            endcase
        end else if (pick < 75) begin
            case ($urandom_range(3))
                0: begin
                    opener  = CH_AMP;
                    partner = CH_AMP;
                end
                1: begin
                    opener  = CH_BAR;
                    partner = CH_BAR;
                end
                2: begin
                    opener  = CH_EQ;
                    partner = CH_EQ;
                end
                default: begin
                    opener  = CH_BANG;
                    partner = CH_EQ;
                end
            endcase
            feed_byte(opener);
            if (pick < 70) begin
                feed_byte(partner);
            end else begin
                // broken two-byte operator
                if ($urandom_range(3) == 0) begin
                    b = $urandom_range(1) ? TERM_NUL : TERM_FF;
                end else begin
                    do b = 8'($urandom_range(255)); while (b == partner);
                end
                feed_byte(b);
            end
        end else if (pick < 84) begin
            feed_byte($urandom_range(1) ? CH_SPACE : 8'($urandom_range(13, 9)));
        end else if (pick < 92) begin
            feed_byte($urandom_range(1) ? TERM_NUL : TERM_FF);
        end else begin
            feed_byte(8'($urandom_range(255)));
        end
    endtask

    // main stimulus
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte  = 8'd0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all operators, whitespace, number closed by an operator,
        // broken pair, dropping, pair cut by a terminator, stray byte
        feed_text("+-*/%;&&||==!= \t7;&xq");
        feed_byte(TERM_FF);
        feed_byte(CH_BANG);
        feed_byte(TERM_NUL);
        feed_byte(CH_AT);
        feed_byte(TERM_NUL);

        // random text, with a long stretch at full rate on both sides
        while (sb.useful < RANDOM_ITEMS + 25) begin
            idle_on = !(sb.useful >= 500 && sb.useful < 800);
            if (!paused && sb.useful >= 1100) begin
                // hold off until the token port has caught up
                paused = 1'b1;
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (sb.pending() != 0);
            end
            random_piece();
        end
        i_in_valid <= 1'b0;

        // drain
        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d tokens never came out", sb.pending()));
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
